// ----- design/ipcf_pkg.sv -----
// Package with shared types and constants for the pitch complementary filter.
`default_nettype none
package ipcf_pkg;

  localparam int unsigned AtanEntries = 24;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ALPHA     = 2'd0,
    REG_GYRO_GAIN = 2'd1,
    REG_GYRO_BIAS = 2'd2
  } reg_idx_e;

  localparam logic [15:0] AlphaReset = 16'd64225;
  localparam logic [31:0] GainReset  = 32'd65574;
  localparam logic [23:0] BiasReset  = 24'd0;

  localparam logic signed [25:0] PitchMax   = 26'sd33554431;
  localparam logic signed [25:0] PitchMin   = -26'sd33554432;
  localparam logic signed [23:0] AccelLimit = 24'sd5898240;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_CORDIC,
    ST_ANGLE,
    ST_GMUL,
    ST_BMUL_A,
    ST_BMUL_B,
    ST_BLEND,
    ST_OUT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic cordic_step;
    logic angle;
    logic gmul;
    logic bmul_a;
    logic bmul_b;
    logic blend;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sqrt_done;
    logic cordic_done;
  } status_t;

  // atan(2^-i) in degrees, Q.24, rounded.
  function automatic logic [29:0] atan_deg(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd754974720;  5'd1: v = 30'd445687602;
      5'd2: v = 30'd235489088;  5'd3: v = 30'd119537938;
      5'd4: v = 30'd60000934;   5'd5: v = 30'd30029717;
      5'd6: v = 30'd15018523;   5'd7: v = 30'd7509720;
      5'd8: v = 30'd3754917;    5'd9: v = 30'd1877466;
      5'd10: v = 30'd938734;    5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;    5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;     5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;     5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;       5'd21: v = 30'd458;
      5'd22: v = 30'd229;       5'd23: v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/ipcf_if.sv -----
// Valid/ready channel interfaces for sample and result words.
`default_nettype none
interface ipcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_y;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_y, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_y, output ready);
endinterface

interface ipcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [25:0] pitch_angle;
  logic signed [23:0] accel_angle;
  logic               saturated;
  modport source (output valid, pitch_angle, accel_angle, saturated, input ready);
  modport sink (input valid, pitch_angle, accel_angle, saturated, output ready);
endinterface
`default_nettype wire

// ----- design/ipcf_ctrl.sv -----
// Sequencing state machine for the pitch filter.
`default_nettype none
module ipcf_ctrl (
  input  var logic             clk_i,
  input  var logic             rst_ni,
  input  var logic             in_valid_i,
  output var logic             in_ready_o,
  output var logic             out_valid_o,
  input  var logic             out_ready_i,
  input  var ipcf_pkg::status_t sts_i,
  output var ipcf_pkg::cmd_t    cmd_o
);
  import ipcf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_done) state_d = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.cordic_done) state_d = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d     = ST_GMUL;
      end
      ST_GMUL: begin
        cmd_o.gmul = 1'b1;
        state_d    = ST_BMUL_A;
      end
      ST_BMUL_A: begin
        cmd_o.bmul_a = 1'b1;
        state_d      = ST_BMUL_B;
      end
      ST_BMUL_B: begin
        cmd_o.bmul_b = 1'b1;
        state_d      = ST_BLEND;
      end
      ST_BLEND: begin
        cmd_o.blend = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_SQRT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/ipcf_dp.sv -----
// Datapath: square root, CORDIC, gyro step and blend arithmetic.
`default_nettype none
module ipcf_dp #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  var logic               clk_i,
  input  var logic               rst_ni,
  input  var ipcf_pkg::cmd_t     cmd_i,
  output var ipcf_pkg::status_t  sts_o,
  input  var logic signed [15:0] accel_x_i,
  input  var logic signed [15:0] accel_y_i,
  input  var logic signed [15:0] accel_z_i,
  input  var logic signed [15:0] gyro_y_i,
  input  var logic [15:0]        alpha_i,
  input  var logic [31:0]        gyro_gain_i,
  input  var logic signed [23:0] gyro_bias_i,
  output var logic signed [25:0] pitch_angle_o,
  output var logic signed [23:0] accel_angle_o,
  output var logic               saturated_o
);
  import ipcf_pkg::*;

  localparam int unsigned Steps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;

  // Radicand is below 2^48; root below 2^24. Two root bits per cycle.
  logic [47:0]        rad_q;
  logic [25:0]        rem_q;
  logic [23:0]        root_q;
  logic [3:0]         sq_cnt_q;
  logic [4:0]         cr_cnt_q;
  logic signed [26:0] cx_q;
  logic signed [25:0] cy_q;
  logic signed [31:0] cz_q;
  logic               ax_zero_q, lvl_zero_q, ax_neg_q;
  logic signed [23:0] acc_q;
  logic signed [24:0] d_q;
  logic signed [15:0] gy_q;
  logic signed [58:0] gprod_q;
  logic signed [55:0] bprod_q;
  logic signed [25:0] pitch_q;
  logic               sat_q;

  // Square-of-level sum, computed at load.
  logic [31:0] sq_y, sq_z;
  logic [32:0] sq_sum;
  always_comb begin
    sq_y   = 32'(accel_y_i * accel_y_i);
    sq_z   = 32'(accel_z_i * accel_z_i);
    sq_sum = {1'b0, sq_y} + {1'b0, sq_z};
  end

  // Two restoring square root steps per cycle.
  logic [25:0] r1, r2, t1, t2;
  logic [23:0] q1, q2;
  always_comb begin
    r1 = {rem_q[23:0], rad_q[47:46]};
    t1 = {root_q, 2'b01};
    if (r1 >= t1) begin r1 = r1 - t1; q1 = {root_q[22:0], 1'b1}; end
    else q1 = {root_q[22:0], 1'b0};
    r2 = {r1[23:0], rad_q[45:44]};
    t2 = {q1, 2'b01};
    if (r2 >= t2) begin r2 = r2 - t2; q2 = {q1[22:0], 1'b1}; end
    else q2 = {q1[22:0], 1'b0};
  end

  // One CORDIC rotation per cycle.
  logic signed [26:0] xs;
  logic signed [25:0] ys;
  logic signed [31:0] at;
  always_comb begin
    xs = cx_q >>> cr_cnt_q;
    ys = cy_q >>> cr_cnt_q;
    at = signed'({2'b00, atan_deg(cr_cnt_q)});
  end

  // Angle rounding and clamp.
  logic signed [23:0] ang_r;
  logic signed [31:0] ang_w;
  always_comb begin
    ang_w = (cz_q + 32'sd128) >>> 8;
    if (ax_zero_q) ang_r = '0;
    else if (lvl_zero_q) ang_r = ax_neg_q ? AccelLimit : -AccelLimit;
    else if (ang_w > 32'(AccelLimit)) ang_r = AccelLimit;
    else if (ang_w < -32'(AccelLimit)) ang_r = -AccelLimit;
    else ang_r = ang_w[23:0];
  end

  // Blend terms. Step is rounded Q.16 from the gyro product; the blend is kept
  // at full width so that only the final clamp limits it.
  logic signed [35:0] step;
  logic signed [36:0] psum;
  logic signed [17:0] a_s, na_s;
  logic signed [55:0] blend_w;
  always_comb begin
    step    = 36'((gprod_q + 59'sd8388608) >>> 24);
    psum    = 37'(pitch_q) + 37'(step);
    a_s     = signed'({2'b00, alpha_i});
    na_s    = 18'sd65536 - a_s;
    blend_w = (bprod_q + 56'sd32768) >>> 16;
  end

  // Multiplications: one per cycle, each registered.
  logic signed [54:0] m_a;
  logic signed [41:0] m_b;
  always_comb begin
    m_a = psum * a_s;
    m_b = acc_q * na_s;
  end

  logic signed [54:0] ma_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rad_q     <= {sq_sum[31:0], 16'd0};
      rem_q     <= '0;
      root_q    <= '0;
      ax_zero_q <= (accel_x_i == 16'sd0);
      lvl_zero_q <= (sq_sum == 33'd0);
      ax_neg_q  <= accel_x_i[15];
      cy_q      <= -(26'(accel_x_i) <<< 8);
      cz_q      <= '0;
      gy_q      <= gyro_y_i;
    end
    if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[43:0], 4'd0};
      rem_q  <= r2;
      root_q <= q2;
      cx_q   <= signed'({3'b000, q2});
    end
    if (cmd_i.cordic_step) begin
      if (cy_q < 0) begin
        cx_q <= cx_q - 27'(ys);
        cy_q <= cy_q + 26'(xs);
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + 27'(ys);
        cy_q <= cy_q - 26'(xs);
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.angle) begin
      acc_q <= ang_r;
      d_q   <= (25'(gy_q) <<< 8) - 25'(gyro_bias_i);
    end
    if (cmd_i.gmul) gprod_q <= d_q * signed'({1'b0, gyro_gain_i});
    if (cmd_i.bmul_a) ma_q <= m_a;
    if (cmd_i.bmul_b) bprod_q <= 56'(ma_q) + 56'(m_b);
  end

  // Counters and kept pitch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
      cr_cnt_q <= '0;
      pitch_q  <= '0;
      sat_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        sq_cnt_q <= '0;
        cr_cnt_q <= '0;
      end
      if (cmd_i.sqrt_step) sq_cnt_q <= sq_cnt_q + 4'd1;
      if (cmd_i.cordic_step) cr_cnt_q <= cr_cnt_q + 5'd1;
      if (cmd_i.blend) begin
        if (blend_w > 56'(PitchMax)) begin
          pitch_q <= PitchMax; sat_q <= 1'b1;
        end else if (blend_w < 56'(PitchMin)) begin
          pitch_q <= PitchMin; sat_q <= 1'b1;
        end else begin
          pitch_q <= blend_w[25:0]; sat_q <= 1'b0;
        end
      end
    end
  end

  assign sts_o.sqrt_done   = (sq_cnt_q == 4'd11);
  assign sts_o.cordic_done = (cr_cnt_q == 5'(Steps - 1));
  assign pitch_angle_o = pitch_q;
  assign accel_angle_o = acc_q;
  assign saturated_o   = sat_q;

endmodule
`default_nettype wire

// ----- design/imu_pitch_complementary_filter.sv -----
// Top level of the IMU pitch complementary filter.
//   channel  dir  payload
//   in_if    in   accel_x, accel_y, accel_z, gyro_y
//   out_if   out  pitch_angle, accel_angle, saturated
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
// Each word takes the square-root steps, then CORDIC_STEPS CORDIC steps (capped at
// 24), then the angle, gyro multiply, two blend multiply and blend states, then the
// output state. The iterative units are shared, so the next word waits for that state.
// Reset clears the kept pitch to zero and the registers to their defaults.
// A result waits in its register until taken; the next word is accepted in that cycle.
`default_nettype none
module imu_pitch_complementary_filter #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  ipcf_in_if.sink         in_if,
  ipcf_out_if.source      out_if,
  input  var logic        cfg_we_i,
  input  var logic [1:0]  cfg_idx_i,
  input  var logic [31:0] cfg_data_i
);
  import ipcf_pkg::*;

  logic [15:0]        alpha_q;
  logic [31:0]        gain_q;
  logic signed [23:0] bias_q;
  cmd_t               cmd;
  status_t            sts;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaReset;
      gain_q  <= GainReset;
      bias_q  <= BiasReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALPHA:     alpha_q <= cfg_data_i[15:0];
        REG_GYRO_GAIN: gain_q  <= cfg_data_i;
        REG_GYRO_BIAS: bias_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  ipcf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ipcf_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .accel_x_i    (in_if.accel_x),
    .accel_y_i    (in_if.accel_y),
    .accel_z_i    (in_if.accel_z),
    .gyro_y_i     (in_if.gyro_y),
    .alpha_i      (alpha_q),
    .gyro_gain_i  (gain_q),
    .gyro_bias_i  (bias_q),
    .pitch_angle_o(out_if.pitch_angle),
    .accel_angle_o(out_if.accel_angle),
    .saturated_o  (out_if.saturated)
  );

endmodule
`default_nettype wire

// ----- design/ipcf_checker.sv -----
// Port-level checks for the pitch filter, bound to the top level.
`default_nettype none
module ipcf_checker (
  input var logic               clk_i,
  input var logic               rst_ni,
  input var logic               in_valid,
  input var logic               in_ready,
  input var logic               out_valid,
  input var logic               out_ready,
  input var logic signed [25:0] pitch_angle,
  input var logic signed [23:0] accel_angle,
  input var logic               saturated
);
  // A new word is accepted only when no result is pending or it is taken now.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> !out_valid || out_ready) else $error("overrun");
  // No result in the cycle after an accept.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid) else $error("early result");
  // Accel angle stays within +/-90 degrees.
  a_accel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> accel_angle <= 24'sd5898240 && accel_angle >= -24'sd5898240)
    else $error("accel range");
  // Saturation flag implies pitch at a rail.
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && saturated |-> pitch_angle == 26'sd33554431 ||
      pitch_angle == -26'sd33554432) else $error("sat rail");
  // A pending result holds steady while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pitch_angle))
    else $error("hold");
endmodule

bind imu_pitch_complementary_filter ipcf_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .pitch_angle(out_if.pitch_angle), .accel_angle(out_if.accel_angle),
  .saturated(out_if.saturated)
);
`default_nettype wire

// ----- sim/tb_imu_pitch_complementary_filter.sv -----
// Testbench for the pitch complementary filter: random samples, predicted results, checks.
module tb_imu_pitch_complementary_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import ipcf_pkg::*;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] gy;
  } sample_t;

  typedef struct packed {
    logic signed [25:0] pitch;
    logic signed [23:0] accel;
    logic               sat;
  } pitch_res_t;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned SettleCycles = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  ipcf_in_if  in_if ();
  ipcf_out_if out_if ();

  imu_pitch_complementary_filter uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state and configuration copy.
  logic [15:0]        m_alpha;
  logic [31:0]        m_gain;
  logic signed [23:0] m_bias;
  longint             m_pitch;

  sample_t    sample_q[$];
  pitch_res_t expected_q[$];
  int         errors = 0;
  bit         tx_idle_en = 1'b1;
  bit         rx_idle_en = 1'b1;
  int         rx_hold = 0;
  bit         stim_done = 1'b0;

  // Floor division by a power of two.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sqrt_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Accelerometer pitch via degree-domain vectoring CORDIC.
  function automatic longint tilt_angle(longint ax, longint ay, longint az);
    longint x, y, z, xs, ys, a, s;
    z = 0;
    if (ax == 0) return 0;
    s = ay * ay + az * az;
    if (s == 0) return (ax < 0) ? longint'(AccelLimit) : -longint'(AccelLimit);
    x = sqrt_floor(s <<< 16);
    y = -ax * 256;
    for (int i = 0; i < 16 && i < 24; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_deg(5'(i)));
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_deg(5'(i)));
      end
    end
    a = floor_shr(z + 128, 8);
    if (a > AccelLimit) a = AccelLimit;
    if (a < -longint'(AccelLimit)) a = -longint'(AccelLimit);
    return a;
  endfunction

  function automatic pitch_res_t predict_pitch(sample_t s);
    pitch_res_t r;
    longint acc, d, stp, sm, bl, al;
    acc = tilt_angle(s.ax, s.ay, s.az);
    al = longint'(m_alpha);
    d = longint'(s.gy) * 256 - longint'(m_bias);
    stp = floor_shr(d * longint'(m_gain) + (64'sd1 <<< 23), 24);
    sm = m_pitch + stp;
    bl = floor_shr(al * sm + (65536 - al) * acc + (64'sd1 <<< 15), 16);
    r.sat = 1'b0;
    if (bl > PitchMax) begin
      bl = PitchMax;
      r.sat = 1'b1;
    end else if (bl < PitchMin) begin
      bl = PitchMin;
      r.sat = 1'b1;
    end
    m_pitch = bl;
    r.pitch = 26'(bl);
    r.accel = 24'(acc);
    return r;
  endfunction

  // Driver: offers pending sample words, with random idle bursts.
  int tx_gap = 0;
  initial begin
    in_if.valid = 1'b0;
    in_if.accel_x = '0;
    in_if.accel_y = '0;
    in_if.accel_z = '0;
    in_if.gyro_y = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      expected_q.push_back(predict_pitch({in_if.accel_x, in_if.accel_y,
                                          in_if.accel_z, in_if.gyro_y}));
      void'(sample_q.pop_front());
    end
    if (rst_ni && (!in_if.valid || in_if.ready)) begin
      // Next word is the head of the queue once the accepted one is popped.
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_if.valid <= 1'b0;
      end else if (tx_idle_en && $urandom_range(0, 5) == 0) begin
        tx_gap <= $urandom_range(0, 6);
        in_if.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.accel_x <= sample_q[0].ax;
        in_if.accel_y <= sample_q[0].ay;
        in_if.accel_z <= sample_q[0].az;
        in_if.gyro_y <= sample_q[0].gy;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result word with the oldest prediction.
  int rx_gap = 0;
  always @(posedge clk_i) begin
    pitch_res_t exp_r;
    if (out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result pitch=%0d accel=%0d sat=%0b", $realtime,
                 out_if.pitch_angle, out_if.accel_angle, out_if.saturated);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.pitch !== out_if.pitch_angle) begin
          $display("%0t: pitch_angle expected %0d actual %0d", $realtime,
                   exp_r.pitch, out_if.pitch_angle);
          errors++;
        end
        if (exp_r.accel !== out_if.accel_angle) begin
          $display("%0t: accel_angle expected %0d actual %0d", $realtime,
                   exp_r.accel, out_if.accel_angle);
          errors++;
        end
        if (exp_r.sat !== out_if.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $realtime,
                   exp_r.sat, out_if.saturated);
          errors++;
        end
      end
    end
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_if.ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_gap <= $urandom_range(0, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted word.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni ||
        stim_done) begin
      quiet <= 0;
    end else if (quiet >= WatchLimit) begin
      $display("[imu_pitch_complementary_filter] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic cfg_write(reg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ALPHA: m_alpha = val[15:0];
      REG_GYRO_GAIN: m_gain = val;
      REG_GYRO_BIAS: m_bias = val[23:0];
      default: ;
    endcase
  endtask

  // Waits until every queued word is accepted and every result has arrived.
  task automatic drain();
    while (sample_q.size() > 0 || expected_q.size() > 0 || in_if.valid)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_random(int n);
    sample_t s;
    for (int k = 0; k < n; k++) begin
      s.ax = rand_axis();
      s.ay = ($urandom_range(0, 15) == 0) ? 16'sd0 : rand_axis();
      s.az = ($urandom_range(0, 15) == 0) ? 16'sd0 : rand_axis();
      s.gy = rand_axis();
      if ($urandom_range(0, 15) == 0) s.ax = 0;
      if ($urandom_range(0, 20) == 0) begin
        s.ay = 0;
        s.az = 0;
      end
      sample_q.push_back(s);
    end
  endtask

  initial begin
    m_alpha = AlphaReset;
    m_gain = GainReset;
    m_bias = BiasReset;
    m_pitch = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: field extremes, zero x axis, missing level vector.
    sample_q.push_back({16'sd0, 16'sd100, 16'sd16384, 16'sd0});
    sample_q.push_back({16'sd1000, 16'sd0, 16'sd0, 16'sd0});
    sample_q.push_back({-16'sd1000, 16'sd0, 16'sd0, 16'sd0});
    sample_q.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    sample_q.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    sample_q.push_back({16'sh8000, 16'sd0, 16'sd1, 16'sh7fff});
    sample_q.push_back({16'sd1, 16'sh8000, 16'sd0, 16'sd0});
    sample_q.push_back({16'sd8192, 16'sd0, 16'sd14189, -16'sd5});
    sample_q.push_back({16'shffff, 16'shffff, 16'shffff, 16'shffff});
    drain();

    // Large gain with full alpha drives the pitch into saturation both ways.
    cfg_write(REG_ALPHA, 32'hffff);
    cfg_write(REG_GYRO_GAIN, 32'hffff_ffff);
    cfg_write(REG_GYRO_BIAS, 32'h0);
    for (int k = 0; k < 6; k++) sample_q.push_back({16'sd0, 16'sd0, 16'sd100, 16'sh7fff});
    for (int k = 0; k < 6; k++) sample_q.push_back({16'sd0, 16'sd0, 16'sd100, 16'sh8000});
    drain();

    cfg_write(REG_ALPHA, 32'h0);
    cfg_write(REG_GYRO_GAIN, 32'h0);
    cfg_write(REG_GYRO_BIAS, 32'h80_0000);
    push_random(100);
    drain();

    // Long receiver hold-off while the sender keeps offering words.
    cfg_write(REG_ALPHA, AlphaReset);
    cfg_write(REG_GYRO_GAIN, 32'h0100_0000);
    cfg_write(REG_GYRO_BIAS, 32'h00_1234);
    push_random(200);
    rx_hold = 400;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(REG_ALPHA, $urandom);
      cfg_write(REG_GYRO_GAIN, (ph == 0) ? $urandom : ($urandom >> $urandom_range(0, 31)));
      cfg_write(REG_GYRO_BIAS, $urandom);
      if (ph == 3) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      push_random(180);
      drain();
    end

    stim_done = 1'b1;
    if (errors == 0) begin
      $display("[imu_pitch_complementary_filter] OK");
    end else begin
      $display("[imu_pitch_complementary_filter] ERROR");
    end
    $finish;
  end
endmodule
